FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on "clock", quiet during "reset".
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/stus_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stus_pkg;

   localparam int TICK_WIDTH_DEF = 64;
   localparam int REAL_QBITS = 56;
   localparam int STEP_W = 7;

   localparam logic [1:0] CMD_TIME  = 2'd0;
   localparam logic [1:0] CMD_SHORT = 2'd1;
   localparam logic [1:0] CMD_REAL  = 2'd2;
   localparam logic [1:0] CMD_RAW   = 2'd3;

   localparam logic [4:0] PRECISION_RESET = 5'b10001;   // -15

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

FILE: hdl/stus_div.sv
`timescale 1ns / 1ps
`default_nettype none

module stus_div #(
   parameter int TICK_WIDTH = stus_pkg::TICK_WIDTH_DEF,
   parameter int QW = stus_pkg::REAL_QBITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire stus_pkg::div_ctl_type   ctl,
   input  wire logic [TICK_WIDTH-1:0]   num,
   input  wire logic [63:0]             den,
   input  wire logic [63:0]             rem_init,
   output stus_pkg::div_sts_type        sts,
   output logic [QW-1:0]                quo,
   output logic [63:0]                  rem
);
   import stus_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [63:0]           r_ff, r_in;
   logic [TICK_WIDTH-1:0] n_ff, n_in;
   logic [QW-1:0]         q_ff, q_in;
   logic [63:0]           d_ff, d_in;
   logic [64:0]           trial;
   logic [64:0]           diff;
   logic                  ge;

   // one restoring step per cycle: bring down a dividend bit, try the subtract
   always_comb begin
      trial = {r_ff, n_ff[TICK_WIDTH-1]};
      diff  = trial - {1'b0, d_ff};
      ge    = trial >= {1'b0, d_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = ctl.steps;
         r_in   = rem_init;
         n_in   = num;
         q_in   = '0;
         d_in   = den;
      end else if (run_ff) begin
         r_in   = ge ? diff[63:0] : trial[63:0];
         n_in   = {n_ff[TICK_WIDTH-2:0], 1'b0};
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign sts.busy = run_ff;
   assign sts.done = done_ff;
   assign quo      = q_ff;
   assign rem      = r_ff;

endmodule

`default_nettype wire

FILE: hdl/sim_time_unit_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// Scales a simulation tick count to a scope's time unit by 10^(unit - precision).
// Request: start with req_command, req_tick_count, req_unit_order; a transaction
// is taken when start is high and busy is low. busy stays high while it works.
// Result: rsp_valid pulses for one cycle with rsp_time_value, rsp_is_real and
// rsp_result_width_is_32; the receiver cannot stall, so it must take it then.
// csr_we/csr_wdata write precision_order (signed 5 bits); write only while idle.
// Flow: raw, zero-tick real, and integer cases with exponent <= 0 or >= 20
// answer in the cycle after acceptance. Integer/short: the x10 multiply loop
// in PREP, then LOAD, the shared restoring divider in DIV, and FIN.
// Real: PREP runs the x10 loop and the normalize shifts (up to 4 bits a cycle)
// together, then RND rounds, then LOAD, DIV and FIN; with exponent <= 0 the
// divider is skipped and RND gives the result. One transaction at a time; a
// new one may be taken in the cycle its predecessor's result shows.
// Reset (synchronous, active high) returns to idle, drops rsp_valid and sets
// precision_order to -15.
module sim_time_unit_scaler #(
   parameter int TICK_WIDTH = stus_pkg::TICK_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_tick_count,
   input  wire logic [4:0]  req_unit_order,
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata,
   output logic             rsp_valid,
   output logic [63:0]      rsp_time_value,
   output logic             rsp_is_real,
   output logic             rsp_result_width_is_32
);
   import stus_pkg::*;

   localparam int QW = (TICK_WIDTH > REAL_QBITS) ? TICK_WIDTH : REAL_QBITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_RND  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   localparam logic [52:0] MANT_ONE = {1'b1, 52'd0};

   logic [2:0]            state_ff, state_in;
   logic [4:0]            prec_ff, prec_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic                  scale_ff, scale_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [63:0]           norm_ff, norm_in;
   logic [6:0]            ea_ff, ea_in;
   logic [63:0]           dint_ff, dint_in;
   logic [52:0]           mb_ff, mb_in;
   logic [6:0]            eb_ff, eb_in;
   logic [52:0]           ma_ff, ma_in;
   logic                  f_ff, f_in;
   logic                  rv_ff, rv_in;
   logic [63:0]           val_ff, val_in;
   logic                  real_ff, real_in;
   logic                  short_ff, short_in;

   logic                  accept;
   logic signed [6:0]     ex_in;
   logic [TICK_WIDTH-1:0] ticks_in;
   logic [63:0]           ticks64;

   // x10 with round-to-nearest-even on the divisor double
   logic [56:0]           p10;
   logic [52:0]           p_m;
   logic                  p_g, p_st, p_inc;
   logic [53:0]           p_sum;
   logic [6:0]            p_eadd;

   logic [52:0]           n_m;
   logic                  n_g, n_st, n_inc;
   logic [53:0]           n_sum;
   logic [6:0]            ea_r;
   logic [52:0]           ma_r;

   logic [55:0]           qr;
   logic [52:0]           q_m;
   logic                  q_g, q_st, q_inc;
   logic [53:0]           q_sum;
   logic [11:0]           q_exp;

   logic [TICK_WIDTH-1:0] qi, qi_rnd;
   logic                  half_up;
   logic                  prep_done;
   logic                  fge;

   div_ctl_type           div_ctl;
   div_sts_type           div_sts;
   logic [TICK_WIDTH-1:0] div_num;
   logic [63:0]           div_den;
   logic [63:0]           div_rem_init;
   logic [QW-1:0]         div_quo;
   logic [63:0]           div_rem;

   assign accept   = start && !busy;
   assign ticks_in = req_tick_count[TICK_WIDTH-1:0];
   assign ticks64  = 64'(ticks_in);
   assign ex_in    = signed'({{2{req_unit_order[4]}}, req_unit_order})
                   - signed'({{2{prec_ff[4]}}, prec_ff});

   always_comb begin
      p10 = (57'(mb_ff) << 3) + (57'(mb_ff) << 1);
      if (p10[56]) begin
         p_m    = p10[56:4];
         p_g    = p10[3];
         p_st   = |p10[2:0];
         p_eadd = 7'd4;
      end else begin
         p_m    = p10[55:3];
         p_g    = p10[2];
         p_st   = |p10[1:0];
         p_eadd = 7'd3;
      end
      p_inc = p_g & (p_st | p_m[0]);
      p_sum = {1'b0, p_m} + 54'(p_inc);

      n_m   = norm_ff[63:11];
      n_g   = norm_ff[10];
      n_st  = |norm_ff[9:0];
      n_inc = n_g & (n_st | n_m[0]);
      n_sum = {1'b0, n_m} + 54'(n_inc);
      ea_r  = ea_ff + 7'(n_sum[53]);
      ma_r  = n_sum[53] ? MANT_ONE : n_sum[52:0];

      qr    = div_quo[55:0];
      q_m   = qr[55:3];
      q_g   = qr[2];
      q_st  = qr[1] | qr[0] | (div_rem != 64'd0);
      q_inc = q_g & (q_st | q_m[0]);
      q_sum = {1'b0, q_m} + 54'(q_inc);
      q_exp = 12'd1022 + 12'(ea_ff) + 12'(f_ff) + 12'(q_sum[53]) - 12'(eb_ff);

      qi      = div_quo[TICK_WIDTH-1:0];
      half_up = div_rem >= (dint_ff >> 1);
      qi_rnd  = qi + TICK_WIDTH'(half_up);

      prep_done = (cnt_ff == 5'd0) && ((cmd_ff != CMD_REAL) || norm_ff[63]);
      fge       = ma_ff >= mb_ff;
   end

   always_comb begin
      state_in = state_ff;
      prec_in  = csr_we ? csr_wdata : prec_ff;
      cmd_in   = cmd_ff;
      tick_in  = tick_ff;
      scale_in = scale_ff;
      cnt_in   = cnt_ff;
      norm_in  = norm_ff;
      ea_in    = ea_ff;
      dint_in  = dint_ff;
      mb_in    = mb_ff;
      eb_in    = eb_ff;
      ma_in    = ma_ff;
      f_in     = f_ff;
      rv_in    = 1'b0;
      val_in   = val_ff;
      real_in  = real_ff;
      short_in = short_ff;
      div_ctl.start = 1'b0;
      div_ctl.steps = STEP_W'(TICK_WIDTH);
      div_num       = tick_ff;
      div_den       = dint_ff;
      div_rem_init  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               tick_in  = ticks_in;
               scale_in = ex_in > 7'sd0;
               cnt_in   = (ex_in > 7'sd0) ? ex_in[4:0] : 5'd0;
               norm_in  = ticks64;
               ea_in    = 7'd63;
               dint_in  = 64'd1;
               mb_in    = MANT_ONE;
               eb_in    = 7'd0;
               real_in  = req_command == CMD_REAL;
               short_in = req_command == CMD_SHORT;
               case (req_command)
                  CMD_RAW: begin
                     val_in = ticks64;
                     rv_in  = 1'b1;
                  end
                  CMD_REAL: begin
                     if (ticks64 == 64'd0) begin
                        val_in = 64'd0;
                        rv_in  = 1'b1;
                     end else begin
                        state_in = ST_PREP;
                     end
                  end
                  default: begin
                     if (ex_in <= 7'sd0) begin
                        val_in = (req_command == CMD_SHORT) ? {32'd0, ticks64[31:0]}
                                                            : ticks64;
                        rv_in  = 1'b1;
                     end else if (ex_in >= 7'sd20) begin
                        val_in = 64'd0;
                        rv_in  = 1'b1;
                     end else begin
                        state_in = ST_PREP;
                     end
                  end
               endcase
            end
         end
         ST_PREP: begin
            if (cnt_ff != 5'd0) begin
               cnt_in  = cnt_ff - 5'd1;
               dint_in = (dint_ff << 3) + (dint_ff << 1);
               mb_in   = p_sum[53] ? MANT_ONE : p_sum[52:0];
               eb_in   = eb_ff + p_eadd + 7'(p_sum[53]);
            end
            if (!norm_ff[63]) begin
               if (norm_ff[63:60] == 4'd0) begin
                  norm_in = norm_ff << 4;
                  ea_in   = ea_ff - 7'd4;
               end else begin
                  norm_in = norm_ff << 1;
                  ea_in   = ea_ff - 7'd1;
               end
            end
            if (prep_done) begin
               state_in = (cmd_ff == CMD_REAL) ? ST_RND : ST_LOAD;
            end
         end
         ST_RND: begin
            ea_in = ea_r;
            ma_in = ma_r;
            if (scale_ff) begin
               state_in = ST_LOAD;
            end else begin
               val_in   = {1'b0, 11'(ea_r) + 11'd1023, ma_r[51:0]};
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            div_ctl.start = 1'b1;
            if (cmd_ff == CMD_REAL) begin
               // keep ma below the divisor so the quotient has its top bit at 55
               f_in          = fge;
               div_ctl.steps = STEP_W'(REAL_QBITS);
               div_num       = '0;
               div_den       = fge ? {10'd0, mb_ff, 1'b0} : {11'd0, mb_ff};
               div_rem_init  = {11'd0, ma_ff};
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (cmd_ff == CMD_REAL) begin
               val_in = {1'b0, q_exp[10:0], q_sum[53] ? 52'd0 : q_sum[51:0]};
            end else if (cmd_ff == CMD_SHORT) begin
               val_in = {32'd0, 32'(qi_rnd)};
            end else begin
               val_in = 64'(qi_rnd);
            end
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prec_ff  <= PRECISION_RESET;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         prec_ff  <= prec_in;
         rv_ff    <= rv_in;
      end
      cmd_ff   <= cmd_in;
      tick_ff  <= tick_in;
      scale_ff <= scale_in;
      cnt_ff   <= cnt_in;
      norm_ff  <= norm_in;
      ea_ff    <= ea_in;
      dint_ff  <= dint_in;
      mb_ff    <= mb_in;
      eb_ff    <= eb_in;
      ma_ff    <= ma_in;
      f_ff     <= f_in;
      val_ff   <= val_in;
      real_ff  <= real_in;
      short_ff <= short_in;
   end

   stus_div #(
      .TICK_WIDTH (TICK_WIDTH),
      .QW         (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .num      (div_num),
      .den      (div_den),
      .rem_init (div_rem_init),
      .sts      (div_sts),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   assign busy                   = state_ff != ST_IDLE;
   assign rsp_valid              = rv_ff;
   assign rsp_time_value         = val_ff;
   assign rsp_is_real            = real_ff;
   assign rsp_result_width_is_32 = short_ff;

`include "assert_macros.svh"

   `ASSERT_CLK(a_flags_exclusive, rsp_valid |-> !(rsp_is_real && rsp_result_width_is_32), "real and short flags both set")
   `ASSERT_CLK(a_rsp_source, rsp_valid |-> $past(state_ff == ST_FIN || state_ff == ST_RND || accept), "result without a finishing step")
   `ASSERT_CLK(a_accept_progress, accept |=> (busy || rsp_valid), "accepted transaction went nowhere")
   `ASSERT_CLK(a_div_running, (state_ff == ST_DIV && !div_sts.done) |-> div_sts.busy, "waiting on an idle divider")
   `ASSERT_CLK_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !busy, "activity right after reset")

endmodule

`default_nettype wire

FILE: dv/tb_sim_time_unit_scaler.sv
`timescale 1ns / 1ps

module tb_sim_time_unit_scaler;
   import stus_pkg::*;

   typedef struct packed {
      logic [63:0] time_value;
      logic        is_real;
      logic        is_short;
   } scaled_time_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = CMD_TIME;
   logic [63:0] req_tick_count = '0;
   logic [4:0]  req_unit_order = '0;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;
   logic        rsp_valid;
   logic [63:0] rsp_time_value;
   logic        rsp_is_real;
   logic        rsp_result_width_is_32;

   logic signed [4:0] precision_q = PRECISION_RESET;
   scaled_time_type   pending_times[$];
   int                mismatch_count = 0;

   sim_time_unit_scaler u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_command            (req_command),
      .req_tick_count         (req_tick_count),
      .req_unit_order         (req_unit_order),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .rsp_valid              (rsp_valid),
      .rsp_time_value         (rsp_time_value),
      .rsp_is_real            (rsp_is_real),
      .rsp_result_width_is_32 (rsp_result_width_is_32)
   );

   always #2 clock = ~clock;

   // integer quotient by 10^ex, rounded half up; 0 once the divisor passes 2^64
   function automatic longint unsigned round_div_pow10(longint unsigned ticks, int ex);
      longint unsigned d;
      d = 1;
      if (ex <= 0) return ticks;
      if (ex >= 20) return 0;
      for (int i = 0; i < ex; i++) d = d * 10;
      return ticks / d + ((ticks % d) + d / 2) / d;
   endfunction

   function automatic scaled_time_type scale_time(logic [1:0] cmd, logic [63:0] ticks,
                                                  logic [4:0] unit);
      scaled_time_type res;
      int              ex;
      real             quot;
      real             s;
      longint unsigned t;
      t = ticks;
      ex = int'($signed(unit)) - int'(precision_q);
      res = '0;
      case (cmd)
         CMD_TIME: res.time_value = round_div_pow10(t, ex);
         CMD_SHORT: begin
            res.time_value = round_div_pow10(t, ex) & 64'hFFFF_FFFF;
            res.is_short = 1'b1;
         end
         CMD_REAL: begin
            s = 1.0;
            for (int i = 0; i < ex; i++) s = s * 10.0;
            quot = real'(t);
            if (ex > 0) quot = quot / s;
            res.time_value = $realtobits(quot);
            res.is_real = 1'b1;
         end
         default: res.time_value = ticks;
      endcase
      return res;
   endfunction

   // result check first, then record the transaction taken at this edge
   always @(posedge clock) begin
      scaled_time_type got;
      scaled_time_type want;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_time_value, rsp_is_real, rsp_result_width_is_32};
            if (pending_times.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %h real=%b short=%b", got.time_value,
                           got.is_real, got.is_short);
            end else begin
               want = pending_times.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp %h real=%b short=%b, got %h real=%b short=%b",
                              want.time_value, want.is_real, want.is_short,
                              got.time_value, got.is_real, got.is_short);
               end
            end
         end
         if (start && !busy)
            pending_times.push_back(scale_time(req_command, req_tick_count, req_unit_order));
         if (csr_we) precision_q <= csr_wdata;
      end
   end

   task automatic send_query(logic [1:0] cmd, logic [63:0] ticks, logic [4:0] unit);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_command = cmd;
      req_tick_count = ticks;
      req_unit_order = unit;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending_times.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic set_precision(logic [4:0] prec);
      drain();
      csr_we = 1'b1;
      csr_wdata = prec;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [63:0] pick_ticks();
      longint unsigned p;
      p = 1;
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 1000));
         2: return {32'h0, $urandom};
         3: begin
            // land on or next to a rounding boundary
            repeat ($urandom_range(1, 19)) p = p * 10;
            return p * $urandom_range(0, 9) + p / 2 + $urandom_range(0, 2) - 1;
         end
         4: return ~64'h0 - $urandom_range(0, 1000);
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   function automatic logic [4:0] pick_unit();
      if ($urandom_range(0, 7) == 0) return 5'($urandom);
      return 5'($signed($urandom_range(0, 17)) - 15);
   endfunction

   task automatic test_directed;
      set_precision(-5'sd15);
      for (int c = 0; c < 4; c++) begin
         send_query(2'(c), 64'h0, 5'd2);
         send_query(2'(c), ~64'h0, 5'd2);
         send_query(2'(c), 64'd1500, -5'sd12);
         send_query(2'(c), 64'd1499, -5'sd12);
         send_query(2'(c), 64'd123456789, -5'sd15);
      end
      // exponent negative, and orders outside the normal range
      set_precision(5'd2);
      send_query(CMD_TIME, 64'hDEAD_BEEF_0123_4567, -5'sd15);
      send_query(CMD_SHORT, 64'hDEAD_BEEF_0123_4567, -5'sd15);
      send_query(CMD_REAL, 64'hDEAD_BEEF_0123_4567, -5'sd15);
      set_precision(-5'sd16);
      send_query(CMD_TIME, ~64'h0, 5'd15);
      send_query(CMD_REAL, ~64'h0, 5'd15);
      send_query(CMD_SHORT, ~64'h0, 5'd3);
   endtask

   task automatic test_precision_sweep;
      logic [4:0] precs[6] = '{-5'sd15, 5'd2, -5'sd16, 5'd15, 5'd0, -5'sd9};
      foreach (precs[i]) begin
         set_precision(precs[i]);
         repeat (30) send_query(2'($urandom), pick_ticks(), pick_unit());
      end
   endtask

   task automatic test_random;
      for (int phase = 0; phase < 12; phase++) begin
         if ($urandom_range(0, 3) == 0) set_precision(5'($urandom));
         else set_precision(5'($signed($urandom_range(0, 17)) - 15));
         repeat (95) send_query(2'($urandom), pick_ticks(), pick_unit());
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_precision_sweep();
      test_random();
      drain();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && pending_times.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/stus_pkg.sv
hdl/stus_div.sv
hdl/sim_time_unit_scaler.sv
dv/tb_sim_time_unit_scaler.sv
